// ===== hdl/uart_command_line_parser_defines.svh =====
// Assertion macros for the checker file of the command line parser.
// Depends on nothing; expects clk and rst_n to be visible at the point of use.
`ifndef UART_COMMAND_LINE_PARSER_DEFINES_SVH
`define UART_COMMAND_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define UCL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("command line parser: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define UCL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("command line parser: next-cycle check failed");

`endif

// ===== hdl/ucl_pkg.sv =====
// Package for the command line parser: character codes, event codes, structs.
// No dependencies.
package ucl_pkg;

    localparam int LINE_CAPACITY_DEF = 32;

    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_1  = 8'h31;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_R  = 8'h52;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam int SETTING_MIN_LEN = 4;
    localparam int TDATA_W         = 32;

    typedef enum logic [1:0] {
        EV_COMMAND = 2'd0,
        EV_SETTING = 2'd1,
        EV_REPORT  = 2'd2
    } ucl_event_t;

    // Line context kept between items (length is held separately, its width
    // follows the line capacity).
    typedef struct packed {
        logic [7:0]  first_char;
        logic [7:0]  second_char;
        logic [15:0] value_acc;
        logic        digits_open;
    } ucl_ctx_t;

    // Result item; event_res sits in the lowest bits.
    typedef struct packed {
        logic        setting_applies;
        logic [15:0] setting_value;
        logic [7:0]  setting_id;
        logic [3:0]  command;
        ucl_event_t  event_res;
    } ucl_result_t;

endpackage

// ===== hdl/ucl_step.sv =====
// One parser step: next line context and optional result for one byte.
// Depends on ucl_pkg.
module ucl_step
    import ucl_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF,
    parameter int LEN_W         = $clog2(LINE_CAPACITY)
)
(
    input  logic [7:0]       rx_byte,
    input  logic [LEN_W-1:0] line_len,
    input  ucl_ctx_t         ctx,
    output logic [LEN_W-1:0] line_len_next,
    output ucl_ctx_t         ctx_next,
    output logic             res_vld,
    output ucl_result_t      res
);

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [LEN_W-1:0] LEN_MIN_S = LEN_W'(SETTING_MIN_LEN);

    logic        is_digit;
    logic        is_eol;
    logic [7:0]  sid;
    logic [15:0] acc_x10;

    assign is_digit = (rx_byte inside {[CHAR_0:CHAR_9]});
    assign is_eol   = (rx_byte == CHAR_LF) || (rx_byte == CHAR_CR);
    assign sid      = ctx.second_char - CHAR_0;
    // acc * 10 + digit, wrapping at 16 bits
    assign acc_x10  = {ctx.value_acc[12:0], 3'b000} + {ctx.value_acc[14:0], 1'b0}
                    + {12'd0, rx_byte[3:0]};

    always_comb
    begin
        line_len_next = line_len;
        ctx_next      = ctx;
        res_vld       = 1'b0;
        res           = '0;

        if ((line_len == '0) && (rx_byte inside {[CHAR_1:CHAR_9]}))
        begin
            // single-digit command, not stored
            res_vld       = 1'b1;
            res.event_res = EV_COMMAND;
            res.command   = rx_byte[3:0];
        end
        else if (is_eol)
        begin
            if ((line_len >= LEN_MIN_S) && (ctx.first_char == CHAR_S))
            begin
                if (ctx.value_acc != '0)
                begin
                    res_vld             = 1'b1;
                    res.event_res       = EV_SETTING;
                    res.setting_id      = sid;
                    res.setting_value   = ctx.value_acc;
                    res.setting_applies = (sid inside {[8'd1:8'd3]});
                end
            end
            else if ((line_len == LEN_W'(1)) && (ctx.first_char == CHAR_R))
            begin
                res_vld       = 1'b1;
                res.event_res = EV_REPORT;
            end
            line_len_next = '0;
            ctx_next      = '0;
        end
        else if (line_len < LEN_LIMIT)
        begin
            case (line_len)
                LEN_W'(0): ctx_next.first_char  = rx_byte;
                LEN_W'(1): ctx_next.second_char = rx_byte;
                LEN_W'(2):
                begin
                    ctx_next.value_acc   = '0;
                    ctx_next.digits_open = 1'b1;
                end
                default:
                begin
                    if (ctx.digits_open)
                    begin
                        if (is_digit)
                            ctx_next.value_acc = acc_x10;
                        else
                            ctx_next.digits_open = 1'b0;
                    end
                end
            endcase
            line_len_next = line_len + LEN_W'(1);
        end
    end

endmodule

// ===== hdl/uart_command_line_parser.sv =====
// Top level of the serial command line parser: input register, step logic,
// output register. Depends on ucl_pkg and ucl_step.
//
// Throughput: one item per cycle unless a held result meets m_tready low;
// the only loop is the line context update in ucl_step.
// Reset (rst_n, async, active low) clears the line context and both valid
// flags; no clearing pass is needed.
module uart_command_line_parser
    import ucl_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] rx_byte
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    // [1:0] event_res, [5:2] command, [13:6] setting_id,
    // [29:14] setting_value, [30] setting_applies, [31] zero
    output logic [TDATA_W-1:0] m_tdata
);

    localparam int LEN_W = $clog2(LINE_CAPACITY);

    // input register
    logic             in_vld_reg;
    logic             in_vld_next;
    logic [7:0]       in_byte_reg;

    // line context
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    ucl_ctx_t         ctx_reg;
    ucl_ctx_t         ctx_next;

    // output register
    logic             out_vld_reg;
    logic             out_vld_next;
    ucl_result_t      out_res_reg;

    logic             res_vld;
    ucl_result_t      res;
    logic             proc;
    logic             in_take;

    // The held byte is processed once the output register is free or is
    // being emptied this cycle.
    assign proc     = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || proc;
    assign in_take  = s_tvalid && s_tready;

    assign in_vld_next = in_take ? 1'b1 : (proc ? 1'b0 : in_vld_reg);

    always_comb
    begin
        if (proc && res_vld)
            out_vld_next = 1'b1;
        else if (m_tready)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    ucl_step #(
        .LINE_CAPACITY (LINE_CAPACITY),
        .LEN_W         (LEN_W)
    ) u_step (
        .rx_byte       (in_byte_reg),
        .line_len      (len_reg),
        .ctx           (ctx_reg),
        .line_len_next (len_next),
        .ctx_next      (ctx_next),
        .res_vld       (res_vld),
        .res           (res)
    );

    // control state and line context
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            len_reg     <= '0;
            ctx_reg     <= '0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (proc)
            begin
                len_reg <= len_next;
                ctx_reg <= ctx_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= s_tdata;
        if (proc && res_vld)
            out_res_reg <= res;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_res_reg};

endmodule

// ===== hdl/ucl_checker.sv =====
// Port-level checks for the command line parser, bound to the top level.
// Depends on ucl_pkg and uart_command_line_parser_defines.svh.
`include "uart_command_line_parser_defines.svh"

module ucl_checker
    import ucl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // a stalled result stays offered
    `UCL_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid)

    // with no result waiting the input side is always open
    `UCL_ASSERT_NOW(a_ready, !m_tvalid, s_tready)

    // no undefined event code
    `UCL_ASSERT_NOW(a_code, m_tvalid, m_tdata[1:0] != 2'd3)

    // command events carry a nonzero command and nothing else
    `UCL_ASSERT_NOW(a_cmd, m_tvalid && (m_tdata[1:0] == EV_COMMAND),
        (m_tdata[5:2] != 4'd0) && (m_tdata[31:6] == 26'd0))

    // setting events carry a nonzero value; applies only for ids 1 to 3
    `UCL_ASSERT_NOW(a_set, m_tvalid && (m_tdata[1:0] == EV_SETTING),
        (m_tdata[29:14] != 16'd0) && (m_tdata[5:2] == 4'd0)
        && (!m_tdata[30] || (m_tdata[13:6] == 8'd1) || (m_tdata[13:6] == 8'd2)
            || (m_tdata[13:6] == 8'd3)))

endmodule

bind uart_command_line_parser ucl_checker u_ucl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
